// File: src/ppm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the pion pair preselect.
package ppm_pkg;

    localparam int MOMENTUM_BITS = 18;
    localparam int MB            = MOMENTUM_BITS;

    // Magnitude of a summed component, its square, and sums of squares.
    localparam int MAG_W = MB + 1;
    localparam int SQR_W = 2 * MAG_W;
    localparam int P2_W  = SQR_W + 2;

    // Square-root unit: radicand is wide enough for |p|^2 in Q.16.
    localparam int FRAC_Q16 = 16;
    localparam int SQ_IN_W  = P2_W + FRAC_Q16;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int REM_W    = SQ_OUT_W + 4;
    localparam int ESUM_W   = SQ_OUT_W + 1;
    localparam int ESQ_W    = 2 * ESUM_W;

    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int LIM2_W   = 2 * CFG_W;
    localparam int FRAC_BITS = 8;
    localparam int WIN_W    = (SQ_OUT_W > CFG_W + FRAC_BITS) ? SQ_OUT_W : CFG_W + FRAC_BITS;

    // Squared pion mass in MeV^2, Q.16.
    localparam logic [31:0] MPI2_Q16 = 32'd1276634318;

    // Pipeline depth from start to done.
    localparam int LATENCY = 2 + SQ_OUT_W + 3 + SQ_OUT_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MASS_MIN        = 3'd0,
        REG_MASS_MAX        = 3'd1,
        REG_DAUGHTER_PT_MAX = 3'd2,
        REG_PAIR_PT_MAX     = 3'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        RSN_PASS       = 3'd0,
        RSN_FLAG       = 3'd1,
        RSN_CHARGE     = 3'd2,
        RSN_ZERO_PT    = 3'd3,
        RSN_MASS       = 3'd4,
        RSN_DAUGHTER_PT = 3'd5,
        RSN_PAIR_PT    = 3'd6
    } reason_t;

    typedef struct packed {
        logic flag_bad;
        logic charge_bad;
        logic zero_bad;
        logic dpt_bad;
        logic ppt_bad;
    } chk_t;

    typedef struct packed {
        chk_t            chk;
        logic [P2_W-1:0] pt2a;
        logic [P2_W-1:0] pt2b;
        logic [P2_W-1:0] pt2s;
        logic [P2_W-1:0] p2a;
        logic [P2_W-1:0] p2b;
        logic [P2_W-1:0] p2s;
    } front_t;

    typedef struct packed {
        chk_t          chk;
        logic [MB-1:0] pt_a;
        logic [MB-1:0] pt_b;
        logic [MB-1:0] pair_pt;
        logic [MB-1:0] p_a;
        logic [MB-1:0] p_b;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [SQ_OUT_W-1:0] root;
    } sq_step_t;

    // One digit of the restoring square root.
    function automatic sq_step_t sqrt_step(input logic [REM_W-1:0] rem,
                                           input logic [SQ_OUT_W-1:0] root,
                                           input logic [1:0] bits);
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] t;
        sq_step_t         s;
        r = {rem[REM_W-3:0], bits};
        t = REM_W'({root, 2'b01});
        if (r >= t)
        begin
            s.rem  = r - t;
            s.root = {root[SQ_OUT_W-2:0], 1'b1};
        end
        else
        begin
            s.rem  = r;
            s.root = {root[SQ_OUT_W-2:0], 1'b0};
        end
        return s;
    endfunction

    function automatic logic [MB-1:0] sat_mb(input logic [SQ_OUT_W-1:0] v);
        logic [MB-1:0] r;
        if (|v[SQ_OUT_W-1:MB])
            r = '1;
        else
            r = v[MB-1:0];
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
        logic [MAG_W-1:0] r;
        r = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
        return r;
    endfunction

endpackage

// File: src/ppm_isqrt.sv
`timescale 1ns / 1ps
// Fully pipelined floor square root, one result digit per register stage.
module ppm_isqrt
    import ppm_pkg::*;
(
    input  logic                clk,
    input  logic [SQ_IN_W-1:0]  rad,
    output logic [SQ_OUT_W-1:0] root
);

    logic [SQ_IN_W-1:0]  rad_reg  [SQ_OUT_W-1];
    logic [REM_W-1:0]    rem_reg  [SQ_OUT_W-1];
    logic [SQ_OUT_W-1:0] root_reg [SQ_OUT_W];

    for (genvar k = 0; k < SQ_OUT_W; k++)
    begin : g_stage
        logic [SQ_IN_W-1:0]  rad_k;
        logic [REM_W-1:0]    rem_k;
        logic [SQ_OUT_W-1:0] root_k;
        sq_step_t            st;

        if (k == 0)
        begin : g_first
            assign rad_k  = rad;
            assign rem_k  = '0;
            assign root_k = '0;
        end
        else
        begin : g_next
            assign rad_k  = rad_reg[k-1];
            assign rem_k  = rem_reg[k-1];
            assign root_k = root_reg[k-1];
        end

        assign st = sqrt_step(rem_k, root_k, rad_k[SQ_IN_W-1 -: 2]);

        always_ff @(posedge clk)
        begin
            root_reg[k] <= st.root;
        end

        if (k < SQ_OUT_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rad_reg[k] <= {rad_k[SQ_IN_W-3:0], 2'b00};
                rem_reg[k] <= st.rem;
            end
        end
    end

    assign root = root_reg[SQ_OUT_W-1];

endmodule

// File: src/ppm_front.sv
`timescale 1ns / 1ps
// Front end: component squares, sums of squares and the early checks.
module ppm_front
    import ppm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [31:0]          cand_flags,
    input  logic                 details_present,
    input  logic signed [1:0]    charge_a,
    input  logic signed [1:0]    charge_b,
    input  logic signed [MB-1:0] px_a,
    input  logic signed [MB-1:0] py_a,
    input  logic signed [MB-1:0] pz_a,
    input  logic signed [MB-1:0] px_b,
    input  logic signed [MB-1:0] py_b,
    input  logic signed [MB-1:0] pz_b,
    input  logic [CFG_W-1:0]     daughter_pt_max,
    input  logic [CFG_W-1:0]     pair_pt_max,
    output logic                 out_valid,
    output front_t               out
);

    // stage 1: squares
    logic              v1_reg;
    logic              flag_bad1_reg;
    logic              charge_bad1_reg;
    logic [SQR_W-1:0]  sxa_reg, sya_reg, sza_reg, sxb_reg, syb_reg, szb_reg;
    logic [SQR_W-1:0]  sxs_reg, sys_reg, szs_reg;
    logic [LIM2_W-1:0] dmax2_reg, pmax2_reg;

    // stage 2: sums and compares
    logic   v2_reg;
    front_t f_reg;

    logic signed [MAG_W-1:0] xa, ya, za, xb, yb, zb, sx, sy, sz;
    logic [MAG_W-1:0] mxa, mya, mza, mxb, myb, mzb, msx, msy, msz;
    logic pos_a, neg_a, pos_b, neg_b;
    logic [P2_W-1:0] pt2a, pt2b, pt2s;

    assign xa = MAG_W'(px_a);
    assign ya = MAG_W'(py_a);
    assign za = MAG_W'(pz_a);
    assign xb = MAG_W'(px_b);
    assign yb = MAG_W'(py_b);
    assign zb = MAG_W'(pz_b);
    assign sx = xa + xb;
    assign sy = ya + yb;
    assign sz = za + zb;

    assign mxa = mag(xa);
    assign mya = mag(ya);
    assign mza = mag(za);
    assign mxb = mag(xb);
    assign myb = mag(yb);
    assign mzb = mag(zb);
    assign msx = mag(sx);
    assign msy = mag(sy);
    assign msz = mag(sz);

    // -2 counts as negative
    assign pos_a = !charge_a[1] && charge_a[0];
    assign neg_a = charge_a[1];
    assign pos_b = !charge_b[1] && charge_b[0];
    assign neg_b = charge_b[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        flag_bad1_reg   <= !cand_flags[0] || !details_present;
        charge_bad1_reg <= !((pos_a && neg_b) || (neg_a && pos_b));
        sxa_reg   <= mxa * mxa;
        sya_reg   <= mya * mya;
        sza_reg   <= mza * mza;
        sxb_reg   <= mxb * mxb;
        syb_reg   <= myb * myb;
        szb_reg   <= mzb * mzb;
        sxs_reg   <= msx * msx;
        sys_reg   <= msy * msy;
        szs_reg   <= msz * msz;
        dmax2_reg <= daughter_pt_max * daughter_pt_max;
        pmax2_reg <= pair_pt_max * pair_pt_max;
    end

    assign pt2a = P2_W'(sxa_reg) + P2_W'(sya_reg);
    assign pt2b = P2_W'(sxb_reg) + P2_W'(syb_reg);
    assign pt2s = P2_W'(sxs_reg) + P2_W'(sys_reg);

    always_ff @(posedge clk)
    begin
        f_reg.chk.flag_bad   <= flag_bad1_reg;
        f_reg.chk.charge_bad <= charge_bad1_reg;
        f_reg.chk.zero_bad   <= (pt2a == '0) || (pt2b == '0);
        f_reg.chk.dpt_bad    <= (pt2a > P2_W'(dmax2_reg)) || (pt2b > P2_W'(dmax2_reg));
        f_reg.chk.ppt_bad    <= pt2s > P2_W'(pmax2_reg);
        f_reg.pt2a <= pt2a;
        f_reg.pt2b <= pt2b;
        f_reg.pt2s <= pt2s;
        f_reg.p2a  <= pt2a + P2_W'(sza_reg);
        f_reg.p2b  <= pt2b + P2_W'(szb_reg);
        f_reg.p2s  <= pt2s + P2_W'(szs_reg);
    end

    assign out_valid = v2_reg;
    assign out       = f_reg;

endmodule

// File: src/pion_pair_mass_preselect.sv
`timescale 1ns / 1ps
// Top level: two-track pion pair invariant mass preselection pipeline.
//
// Usage:
//   Input: drive the candidate fields and pulse start. A beat is taken at every
//   clock edge with start high; busy is always low, so a new candidate may
//   enter every cycle.
//   Output: exactly one result per candidate, after the front end, both root
//   chains and the output register, shown for one cycle with done high.
//   Results come out in input order; the receiver cannot stall the pipeline.
//   Throughput: one candidate per clock. The depth is set by two chained
//   digit-per-stage square roots (pion energies, then the pair mass), each
//   SQ_OUT_W stages deep, plus squares, sums and the energy product.
//   Config: cfg_valid/cfg_ready write port, always ready. Index 0 mass_min,
//   1 mass_max, 2 daughter_pt_max, 3 pair_pt_max; other indexes are dropped.
//   Write only while no candidate is in flight.
//   Reset: clears all valid bits and loads the default window 400..600 MeV,
//   daughter pt limit 5000 MeV and pair pt limit 3000 MeV.
module pion_pair_mass_preselect
    import ppm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [31:0]          cand_flags,
    input  logic                 details_present,
    input  logic signed [1:0]    charge_a,
    input  logic signed [1:0]    charge_b,
    input  logic signed [MB-1:0] px_a,
    input  logic signed [MB-1:0] py_a,
    input  logic signed [MB-1:0] pz_a,
    input  logic signed [MB-1:0] px_b,
    input  logic signed [MB-1:0] py_b,
    input  logic signed [MB-1:0] pz_b,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 done,
    output logic                 accepted,
    output logic [2:0]           reject_reason,
    output logic [MB-1:0]        pair_mass,
    output logic [MB-1:0]        pair_pt,
    output logic [MB-1:0]        pt_a,
    output logic [MB-1:0]        pt_b,
    output logic [MB-1:0]        p_a,
    output logic [MB-1:0]        p_b
);

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] mass_min_reg, mass_max_reg, dpt_max_reg, ppt_max_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_min_reg <= 16'd400;
            mass_max_reg <= 16'd600;
            dpt_max_reg  <= 16'd5000;
            ppt_max_reg  <= 16'd3000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MASS_MIN:        mass_min_reg <= cfg_data;
                REG_MASS_MAX:        mass_max_reg <= cfg_data;
                REG_DAUGHTER_PT_MAX: dpt_max_reg  <= cfg_data;
                REG_PAIR_PT_MAX:     ppt_max_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    // ---------------- front end: squares and early checks ----------------
    logic   f_valid;
    front_t f;

    ppm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (start && !busy),
        .cand_flags      (cand_flags),
        .details_present (details_present),
        .charge_a        (charge_a),
        .charge_b        (charge_b),
        .px_a            (px_a),
        .py_a            (py_a),
        .pz_a            (pz_a),
        .px_b            (px_b),
        .py_b            (py_b),
        .pz_b            (pz_b),
        .daughter_pt_max (dpt_max_reg),
        .pair_pt_max     (ppt_max_reg),
        .out_valid       (f_valid),
        .out             (f)
    );

    // ---------------- phase 1: energies and magnitude roots ----------------
    logic [SQ_IN_W-1:0]  rad_ea, rad_eb;
    logic [SQ_OUT_W-1:0] ea, eb, r_pta, r_ptb, r_pts, r_pa, r_pb;

    // E^2 in Q.16 = |p|^2 * 2^16 + m_pi^2
    assign rad_ea = SQ_IN_W'({f.p2a, 16'b0}) + SQ_IN_W'(MPI2_Q16);
    assign rad_eb = SQ_IN_W'({f.p2b, 16'b0}) + SQ_IN_W'(MPI2_Q16);

    ppm_isqrt u_sq_ea  (.clk(clk), .rad(rad_ea),              .root(ea));
    ppm_isqrt u_sq_eb  (.clk(clk), .rad(rad_eb),              .root(eb));
    ppm_isqrt u_sq_pta (.clk(clk), .rad(SQ_IN_W'(f.pt2a)),    .root(r_pta));
    ppm_isqrt u_sq_ptb (.clk(clk), .rad(SQ_IN_W'(f.pt2b)),    .root(r_ptb));
    ppm_isqrt u_sq_pts (.clk(clk), .rad(SQ_IN_W'(f.pt2s)),    .root(r_pts));
    ppm_isqrt u_sq_pa  (.clk(clk), .rad(SQ_IN_W'(f.p2a)),     .root(r_pa));
    ppm_isqrt u_sq_pb  (.clk(clk), .rad(SQ_IN_W'(f.p2b)),     .root(r_pb));

    // side band travels beside the roots
    logic            v_p1_reg   [SQ_OUT_W];
    chk_t            chk_p1_reg [SQ_OUT_W];
    logic [P2_W-1:0] p2s_p1_reg [SQ_OUT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SQ_OUT_W; i++)
                v_p1_reg[i] <= 1'b0;
        end
        else
        begin
            v_p1_reg[0] <= f_valid;
            for (int i = 1; i < SQ_OUT_W; i++)
                v_p1_reg[i] <= v_p1_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        chk_p1_reg[0] <= f.chk;
        p2s_p1_reg[0] <= f.p2s;
        for (int i = 1; i < SQ_OUT_W; i++)
        begin
            chk_p1_reg[i] <= chk_p1_reg[i-1];
            p2s_p1_reg[i] <= p2s_p1_reg[i-1];
        end
    end

    // ---------------- A: energy sum, B: square, C: m^2 ----------------
    logic                va_reg, vb_reg, vc_reg;
    logic [ESUM_W-1:0]   esum_a_reg;
    logic [ESQ_W-1:0]    esq_b_reg;
    logic [SQ_IN_W-1:0]  m2_c_reg;
    logic [P2_W-1:0]     p2s_a_reg, p2s_b_reg;
    side_t               side_a_reg, side_b_reg, side_c_reg;
    logic [ESQ_W-1:0]    psq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= v_p1_reg[SQ_OUT_W-1];
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    assign psq = ESQ_W'({p2s_b_reg, 16'b0});

    always_ff @(posedge clk)
    begin
        esum_a_reg         <= ESUM_W'(ea) + ESUM_W'(eb);
        p2s_a_reg          <= p2s_p1_reg[SQ_OUT_W-1];
        side_a_reg.chk     <= chk_p1_reg[SQ_OUT_W-1];
        side_a_reg.pt_a    <= sat_mb(r_pta);
        side_a_reg.pt_b    <= sat_mb(r_ptb);
        side_a_reg.pair_pt <= sat_mb(r_pts);
        side_a_reg.p_a     <= sat_mb(r_pa);
        side_a_reg.p_b     <= sat_mb(r_pb);

        esq_b_reg  <= esum_a_reg * esum_a_reg;
        p2s_b_reg  <= p2s_a_reg;
        side_b_reg <= side_a_reg;

        // clamp a negative m^2 at zero
        if (esq_b_reg > psq)
        begin
            m2_c_reg <= SQ_IN_W'(esq_b_reg - psq);
        end
        else
        begin
            m2_c_reg <= '0;
        end
        side_c_reg <= side_b_reg;
    end

    // ---------------- phase 2: pair mass root ----------------
    logic [SQ_OUT_W-1:0] mass_q;

    ppm_isqrt u_sq_mass (.clk(clk), .rad(m2_c_reg), .root(mass_q));

    logic  v_p2_reg    [SQ_OUT_W];
    side_t side_p2_reg [SQ_OUT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SQ_OUT_W; i++)
                v_p2_reg[i] <= 1'b0;
        end
        else
        begin
            v_p2_reg[0] <= vc_reg;
            for (int i = 1; i < SQ_OUT_W; i++)
                v_p2_reg[i] <= v_p2_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_p2_reg[0] <= side_c_reg;
        for (int i = 1; i < SQ_OUT_W; i++)
            side_p2_reg[i] <= side_p2_reg[i-1];
    end

    // ---------------- final: checks in priority order ----------------
    side_t         sd;
    logic          mass_bad;
    reason_t       reason;
    logic          done_reg;
    logic          accepted_reg;
    reason_t       reason_reg;
    logic [MB-1:0] pair_mass_reg;
    side_t         out_reg;

    assign sd = side_p2_reg[SQ_OUT_W-1];

    // window edges compared in Q.8
    assign mass_bad = (WIN_W'(mass_q) < WIN_W'({mass_min_reg, 8'b0}))
                   || (WIN_W'(mass_q) > WIN_W'({mass_max_reg, 8'b0}));

    always_comb
    begin
        if (sd.chk.flag_bad)
            reason = RSN_FLAG;
        else if (sd.chk.charge_bad)
            reason = RSN_CHARGE;
        else if (sd.chk.zero_bad)
            reason = RSN_ZERO_PT;
        else if (mass_bad)
            reason = RSN_MASS;
        else if (sd.chk.dpt_bad)
            reason = RSN_DAUGHTER_PT;
        else if (sd.chk.ppt_bad)
            reason = RSN_PAIR_PT;
        else
            reason = RSN_PASS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v_p2_reg[SQ_OUT_W-1];
    end

    always_ff @(posedge clk)
    begin
        accepted_reg  <= (reason == RSN_PASS);
        reason_reg    <= reason;
        pair_mass_reg <= sat_mb(SQ_OUT_W'(mass_q >> FRAC_BITS));
        out_reg       <= sd;
    end

    assign done          = done_reg;
    assign accepted      = accepted_reg;
    assign reject_reason = reason_reg;
    assign pair_mass     = pair_mass_reg;
    assign pair_pt       = out_reg.pair_pt;
    assign pt_a          = out_reg.pt_a;
    assign pt_b          = out_reg.pt_b;
    assign p_a           = out_reg.p_a;
    assign p_b           = out_reg.p_b;

    // ---------------- assertions ----------------
    // every result traces back to a start that passed through the whole pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without matching start");

    // accept flag agrees with the reason code
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (accepted == (reject_reason == RSN_PASS)))
        else $error("accepted disagrees with reject_reason");

    // a flag or charge failure upstream always ends in a reject
    a_side: assert property (@(posedge clk) disable iff (!rst_n)
        v_p2_reg[SQ_OUT_W-1] && (sd.chk.flag_bad || sd.chk.charge_bad) |=>
            done && !accepted)
        else $error("early reject lost in pipeline");

endmodule
